// File: design/layer_pixel_blend_blit_defines.svh
// Assertion macros shared by the blitter RTL.
// The clocked forms expect signals named clk and rst_n in the calling scope.
`ifndef LAYER_PIXEL_BLEND_BLIT_DEFINES_SVH
`define LAYER_PIXEL_BLEND_BLIT_DEFINES_SVH

`ifndef SYNTHESIS
`define LPBB_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("layer_pixel_blend_blit: assertion failed");
`define LPBB_ASSERT_NEVER(label, cond) \
    `LPBB_ASSERT(label, !(cond))
`else
`define LPBB_ASSERT(label, prop)
`define LPBB_ASSERT_NEVER(label, cond)
`endif

`endif

// File: design/lpbb_pkg.sv
`timescale 1ns / 1ps

package lpbb_pkg;

    localparam int PIXEL_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int SIZE_W     = 13;

    // Blend mode codes. Any code other than alpha or key copies the source.
    localparam logic [1:0] MODE_OPAQUE = 2'd0;
    localparam logic [1:0] MODE_ALPHA  = 2'd1;
    localparam logic [1:0] MODE_KEY    = 2'd2;
    localparam logic [1:0] MODE_SPARE  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OPACITY       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHROMA_KEY    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_HEIGHT = 3'd5;

    localparam logic [7:0] FULL_OPACITY = 8'hFF;
    localparam logic [2:0] BPP_FOUR     = 3'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  opacity;
        logic [23:0] chroma_key;
        logic        four_bytes;
    } pix_cfg_t;

endpackage

// File: design/lpbb_pixel_op.sv
`timescale 1ns / 1ps

`include "layer_pixel_blend_blit_defines.svh"

// Per-pixel operation: constant alpha blend, color key test or copy.
module lpbb_pixel_op (
    input  lpbb_pkg::pix_cfg_t             cfg,
    input  logic [lpbb_pkg::PIXEL_W-1:0]   src_pixel,
    input  logic [lpbb_pkg::PIXEL_W-1:0]   dst_pixel,
    output logic [lpbb_pkg::PIXEL_W-1:0]   result_pixel,
    output logic                           write_enable
);

    logic [7:0]                  inv_alpha;
    logic [23:0]                 blend_rgb;
    logic [lpbb_pkg::PIXEL_W-1:0] copy_pixel;
    logic [lpbb_pkg::PIXEL_W-1:0] blend_pixel;
    logic                        key_hit;

    assign inv_alpha = lpbb_pkg::FULL_OPACITY - cfg.opacity;

    // Each color byte: (s*a + d*(255-a)) / 255. The division is exact for
    // sums below 2^16 as (x + (x >> 8) + 1) >> 8.
    for (genvar lane = 0; lane < 3; lane++) begin : g_lane
        logic [15:0] prod_s;
        logic [15:0] prod_d;
        logic [16:0] mix_sum;
        logic [16:0] div_sum;

        assign prod_s  = src_pixel[8*lane +: 8] * cfg.opacity;
        assign prod_d  = dst_pixel[8*lane +: 8] * inv_alpha;
        assign mix_sum = {1'b0, prod_s} + {1'b0, prod_d};
        assign div_sum = mix_sum + {8'd0, mix_sum[16:8]} + 17'd1;
        assign blend_rgb[8*lane +: 8] = div_sum[15:8];
    end

    assign copy_pixel  = cfg.four_bytes ? src_pixel : {dst_pixel[31:24], src_pixel[23:0]};
    assign blend_pixel = {dst_pixel[31:24], blend_rgb};
    assign key_hit     = (src_pixel[23:0] == cfg.chroma_key);

    always_comb
    begin
        result_pixel = copy_pixel;
        write_enable = 1'b1;
        unique case (cfg.mode)
            lpbb_pkg::MODE_ALPHA:
            begin
                if (cfg.opacity != lpbb_pkg::FULL_OPACITY)
                begin
                    result_pixel = blend_pixel;
                end
            end
            lpbb_pkg::MODE_KEY:
            begin
                if (key_hit)
                begin
                    result_pixel = dst_pixel;
                    write_enable = 1'b0;
                end
            end
            default:
            begin
                result_pixel = copy_pixel;
            end
        endcase
    end

endmodule

// File: design/layer_pixel_blend_blit.sv
`timescale 1ns / 1ps
// Pipeline: two register stages, the input register and the result register; an
// item moves on when the result register is empty or taken. Throughput: one item
// per cycle while the result side flows. With the result side stalled, the input
// register takes one more item, then s_tready stays low until m_tready returns.
// Reset: rst_n (asynchronous, active low) clears the valid flags and counters and
// loads the defaults (opaque, opacity 255, key 0, four bytes, 4096 by 4096).

`include "layer_pixel_blend_blit_defines.svh"

module layer_pixel_blend_blit #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        clk,
    input  logic        rst_n,

    // Configuration write channel. Writes are always taken.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lpbb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lpbb_pkg::CFG_DATA_W-1:0]   cfg_data,

    // Pixel pair input.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // [31:0] src_pixel, [63:32] dst_pixel

    // Result output.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] result_pixel
    output logic [1:0]  m_tuser,    // [0] write_enable, [1] row_end
    output logic        m_tlast     // region_end
);

    // Counter widths follow the largest region; the compare width also holds
    // the maximum size itself.
    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CMPW_W = $clog2(MAX_WIDTH + 1) + 1;
    localparam int CMPH_W = $clog2(MAX_HEIGHT + 1) + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [1:0]                    blend_mode_reg;
    logic [7:0]                    opacity_reg;
    logic [23:0]                   chroma_key_reg;
    logic [2:0]                    bytes_per_pixel_reg;
    logic [lpbb_pkg::SIZE_W-1:0]   region_width_reg;
    logic [lpbb_pkg::SIZE_W-1:0]   region_height_reg;
    logic                          cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_mode_reg      <= lpbb_pkg::MODE_OPAQUE;
            opacity_reg         <= lpbb_pkg::FULL_OPACITY;
            chroma_key_reg      <= 24'd0;
            bytes_per_pixel_reg <= lpbb_pkg::BPP_FOUR;
            region_width_reg    <= 13'd4096;
            region_height_reg   <= 13'd4096;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                lpbb_pkg::REG_BLEND_MODE:    blend_mode_reg      <= cfg_data[1:0];
                lpbb_pkg::REG_OPACITY:       opacity_reg         <= cfg_data[7:0];
                lpbb_pkg::REG_CHROMA_KEY:    chroma_key_reg      <= cfg_data[23:0];
                lpbb_pkg::REG_BYTES_PER_PIX: bytes_per_pixel_reg <= cfg_data[2:0];
                lpbb_pkg::REG_REGION_WIDTH:  region_width_reg    <= cfg_data[12:0];
                lpbb_pkg::REG_REGION_HEIGHT: region_height_reg   <= cfg_data[12:0];
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Effective region size. Zero counts as one, and anything above the
    // maximum counts as the maximum.
    // ------------------------------------------------------------------
    logic [CMPW_W-1:0] width_eff;
    logic [CMPH_W-1:0] height_eff;

    always_comb
    begin
        priority if (region_width_reg == '0)
            width_eff = CMPW_W'(1);
        else if (32'(region_width_reg) > MAX_WIDTH)
            width_eff = CMPW_W'(MAX_WIDTH);
        else
            width_eff = CMPW_W'(region_width_reg);

        priority if (region_height_reg == '0)
            height_eff = CMPH_W'(1);
        else if (32'(region_height_reg) > MAX_HEIGHT)
            height_eff = CMPH_W'(MAX_HEIGHT);
        else
            height_eff = CMPH_W'(region_height_reg);
    end

    // ------------------------------------------------------------------
    // Handshake and pipeline control. Stage 1 is the input register, stage 2
    // the result register that drives the master side.
    // ------------------------------------------------------------------
    logic s1_valid_reg, s1_valid_next;
    logic m_valid_reg, m_valid_next;
    logic out_load;
    logic in_accept;

    assign out_load  = !m_valid_reg || m_tready;
    assign s_tready  = !s1_valid_reg || out_load;
    assign in_accept = s_tvalid && s_tready;

    assign s1_valid_next = in_accept ? 1'b1 : (out_load ? 1'b0 : s1_valid_reg);
    assign m_valid_next  = out_load ? s1_valid_reg : m_valid_reg;

    // ------------------------------------------------------------------
    // Raster position. The counters advance once per accepted item, and the
    // row and region marks are decided at acceptance. A column count at or past a
    // shrunk width ends the row at once; a row count ends the region with that row.
    // ------------------------------------------------------------------
    logic [COL_W-1:0] col_count_reg, col_count_next;
    logic [ROW_W-1:0] row_count_reg, row_count_next;
    logic             col_last;
    logic             row_last;

    assign col_last = (CMPW_W'(col_count_reg) + CMPW_W'(1)) >= width_eff;
    assign row_last = (CMPH_W'(row_count_reg) + CMPH_W'(1)) >= height_eff;

    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (in_accept)
        begin
            if (col_last)
            begin
                col_count_next = '0;
                row_count_next = row_last ? '0 : row_count_reg + ROW_W'(1);
            end
            else
            begin
                col_count_next = col_count_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            m_valid_reg   <= m_valid_next;
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register with the position marks.
    // ------------------------------------------------------------------
    logic [31:0] src_reg, src_next;
    logic [31:0] dst_reg, dst_next;
    logic        row_end_reg, row_end_next;
    logic        region_end_reg, region_end_next;

    assign src_next        = in_accept ? s_tdata[31:0] : src_reg;
    assign dst_next        = in_accept ? s_tdata[63:32] : dst_reg;
    assign row_end_next    = in_accept ? col_last : row_end_reg;
    assign region_end_next = in_accept ? (col_last && row_last) : region_end_reg;

    always_ff @(posedge clk)
    begin
        src_reg        <= src_next;
        dst_reg        <= dst_next;
        row_end_reg    <= row_end_next;
        region_end_reg <= region_end_next;
    end

    // ------------------------------------------------------------------
    // Pixel operation between the two registers. Configuration must only change
    // while the block is idle (not enforced); the live registers serve every item.
    // ------------------------------------------------------------------
    lpbb_pkg::pix_cfg_t pix_cfg;
    logic [31:0]        op_pixel;
    logic               op_write_enable;

    assign pix_cfg.mode       = blend_mode_reg;
    assign pix_cfg.opacity    = opacity_reg;
    assign pix_cfg.chroma_key = chroma_key_reg;
    assign pix_cfg.four_bytes = (bytes_per_pixel_reg == lpbb_pkg::BPP_FOUR);

    lpbb_pixel_op u_pixel_op (
        .cfg          (pix_cfg),
        .src_pixel    (src_reg),
        .dst_pixel    (dst_reg),
        .result_pixel (op_pixel),
        .write_enable (op_write_enable)
    );

    // ------------------------------------------------------------------
    // Stage 2: result register.
    // ------------------------------------------------------------------
    logic [31:0] result_reg, result_next;
    logic [1:0]  user_reg, user_next;
    logic        last_reg, last_next;
    logic        s2_load;

    assign s2_load     = out_load && s1_valid_reg;
    assign result_next = s2_load ? op_pixel : result_reg;
    assign user_next   = s2_load ? {row_end_reg, op_write_enable} : user_reg;
    assign last_next   = s2_load ? region_end_reg : last_reg;

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        user_reg   <= user_next;
        last_reg   <= last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = result_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The end of the region is always also the end of a row.
    `LPBB_ASSERT(a_region_end_is_row_end, (m_valid_reg && last_reg) |-> user_reg[1])
    // Only a key match suppresses the write.
    `LPBB_ASSERT_NEVER(a_skip_only_in_key_mode,
        m_valid_reg && !user_reg[0] && (blend_mode_reg != lpbb_pkg::MODE_KEY))
    // Finishing the region returns both counters to the origin.
    `LPBB_ASSERT(a_region_wraps, (in_accept && col_last && row_last) |=>
        (col_count_reg == '0 && row_count_reg == '0))
    // A held item in stage 1 is never dropped while the result side stalls.
    `LPBB_ASSERT(a_stage1_held, (s1_valid_reg && !out_load) |=>
        (s1_valid_reg && $stable(src_reg) && $stable(dst_reg)))

endmodule
